### rtl/mac_table_hash_insert_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the MAC table hash insert block
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef MAC_TABLE_HASH_INSERT_ASSERT_SVH
`define MAC_TABLE_HASH_INSERT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset
`define MTHI_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("mac_table_hash_insert: property failed");
// Check that a condition leads to a consequence in the next cycle
`define MTHI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mac_table_hash_insert: sequence failed");
`else
`define MTHI_ASSERT(label, prop)
`define MTHI_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### rtl/mthi_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mthi_pkg
// Shared widths, codes and types of the MAC table hash insert block.
// ---------------------------------------------------------------------------
package mthi_pkg;

  // Field widths
  localparam int MacW    = 48;
  localparam int HashW   = 11;
  localparam int SlotW   = 12;
  localparam int LevelW  = 2;
  localparam int OutCntW = 32;

  // Occupancy rows: 32 slots per memory word
  localparam int RowW    = 32;
  localparam int BitIdxW = 5;

  // Base slots of the overflow levels
  localparam logic [SlotW-1:0] Level1Base = 12'd2048;
  localparam logic [SlotW-1:0] Level2Base = 12'd3072;
  localparam logic [SlotW-1:0] Level3Base = 12'd3584;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_CLEAR  = 1'b1
  } op_e;

  typedef enum logic [LevelW-1:0] {
    LVL_PRIMARY = 2'd0,
    LVL_SECOND  = 2'd1,
    LVL_THIRD   = 2'd2,
    LVL_FOURTH  = 2'd3
  } level_e;

  // Classified job as queued between front and back
  typedef struct packed {
    op_e              op;
    logic [HashW-1:0] hash;
  } job_t;

  // Head of the job queue toward the back end
  typedef struct packed {
    logic valid;
    job_t job;
  } fe_req_t;

  // Back end status toward the front end
  typedef struct packed {
    logic sweeping;
  } be_stat_t;

endpackage

### rtl/mthi_in_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mthi_in_if
// Request channel: operation code and MAC address with valid/ready.
// ---------------------------------------------------------------------------
interface mthi_in_if import mthi_pkg::*; ();
  logic            valid;
  logic            ready;
  op_e             op;
  logic [MacW-1:0] mac_address;

  modport source (output valid, output op, output mac_address, input ready);
  modport sink   (input valid, input op, input mac_address, output ready);
endinterface

### rtl/mthi_out_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mthi_out_if
// Result channel: placement outcome and counter snapshot with valid/ready.
// ---------------------------------------------------------------------------
interface mthi_out_if import mthi_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               placed;
  logic [LevelW-1:0]  level;
  logic [SlotW-1:0]   slot;
  logic [OutCntW-1:0] collisions_level1;
  logic [OutCntW-1:0] collisions_level2;
  logic [OutCntW-1:0] collisions_level3;
  logic [OutCntW-1:0] collisions_level4;
  logic [OutCntW-1:0] probes_level2;
  logic [OutCntW-1:0] probes_level3;
  logic [OutCntW-1:0] probes_level4;

  modport source (
    output valid, output placed, output level, output slot,
    output collisions_level1, output collisions_level2,
    output collisions_level3, output collisions_level4,
    output probes_level2, output probes_level3, output probes_level4,
    input  ready
  );
  modport sink (
    input  valid, input placed, input level, input slot,
    input  collisions_level1, input collisions_level2,
    input  collisions_level3, input collisions_level4,
    input  probes_level2, input probes_level3, input probes_level4,
    output ready
  );
endinterface

### rtl/mthi_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mthi_front
// Accepts requests, folds the MAC address into an 11-bit hash and queues
// the classified job for the back end in a two-entry queue.
// ---------------------------------------------------------------------------
module mthi_front import mthi_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  mthi_in_if.sink  in_i,
  input  be_stat_t stat_i,
  input  logic     pop_i,
  output fe_req_t  req_o
);

  localparam int QDepth = 2;
  localparam int PtrW   = $clog2(QDepth);

  logic [23:0]      fold_x;
  logic [11:0]      fold_f;
  job_t             job_in;
  logic             push;
  job_t             q_mem_q [QDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]    cnt_q;

  // Fold the address: halves of 24, then halves of 12, keep 11 bits
  always_comb begin
    fold_x      = in_i.mac_address[47:24] ^ in_i.mac_address[23:0];
    fold_f      = fold_x[11:0] ^ fold_x[23:12];
    job_in.op   = in_i.op;
    job_in.hash = fold_f[HashW-1:0];
  end

  // Hold off requests while the table is swept or the queue is full
  assign in_i.ready = !stat_i.sweeping && (cnt_q != (PtrW+1)'(QDepth));
  assign push       = in_i.valid && in_i.ready;

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= job_in;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign req_o.valid = (cnt_q != '0);
  assign req_o.job   = q_mem_q[rd_ptr_q];

endmodule

### rtl/mthi_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mthi_back
// Runs queued jobs against four occupancy banks read in parallel, keeps the
// saturating collision and probe counters and drives the result register.
// ---------------------------------------------------------------------------
`include "mac_table_hash_insert_assert.svh"

module mthi_back import mthi_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  fe_req_t     req_i,
  output logic        pop_o,
  output be_stat_t    stat_o,
  mthi_out_if.source  out_o
);

  localparam int Bank0Rows = 2048 / RowW;
  localparam int Bank1Rows = 1024 / RowW;
  localparam int Bank2Rows = 512 / RowW;
  localparam int Row0W     = $clog2(Bank0Rows);
  localparam int Row1W     = $clog2(Bank1Rows);
  localparam int Row2W     = $clog2(Bank2Rows);
  localparam int ExtW      = (COUNT_BITS > OutCntW) ? COUNT_BITS : OutCntW;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_EVAL
  } state_e;

  // Occupancy banks, one per level
  logic [RowW-1:0] bank0_mem [Bank0Rows];
  logic [RowW-1:0] bank1_mem [Bank1Rows];
  logic [RowW-1:0] bank2_mem [Bank2Rows];
  logic [RowW-1:0] bank3_mem [Bank2Rows];

  state_e              state_q;
  logic [Row0W-1:0]    sweep_row_q;
  logic                reply_q;
  job_t                job_q;
  logic [RowW-1:0]     rd_q [4];
  logic [COUNT_BITS-1:0] col_q [4];
  logic [COUNT_BITS-1:0] col_d [4];
  logic [COUNT_BITS-1:0] prb_q [3];
  logic [COUNT_BITS-1:0] prb_d [3];
  logic                out_valid_q;
  logic                placed_q;
  level_e              level_q;
  logic [SlotW-1:0]    slot_q;

  logic                out_free;
  logic                clr_start;
  logic [BitIdxW-1:0]  bit_idx;
  logic [3:0]          occ;
  logic [3:0]          reach;
  logic [3:0]          place;
  logic                placed_d;
  level_e              level_d;
  logic [SlotW-1:0]    slot_d;
  logic [3:0]          we;
  logic [Row0W-1:0]    wa0;
  logic [Row1W-1:0]    wa1;
  logic [Row2W-1:0]    wa2;
  logic [RowW-1:0]     wd [4];
  logic [RowW-1:0]     bit_mask;
  logic [ExtW-1:0]     col_x [4];
  logic [ExtW-1:0]     prb_x [3];

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // Take a job only when the result register is free by the next edge
  assign out_free        = !out_valid_q || out_o.ready;
  assign pop_o           = (state_q == ST_IDLE) && req_i.valid && out_free;
  assign clr_start       = pop_o && (req_i.job.op == OP_CLEAR);
  assign stat_o.sweeping = (state_q == ST_SWEEP);

  // Probe chain over the four levels
  always_comb begin
    bit_idx  = job_q.hash[BitIdxW-1:0];
    for (int k = 0; k < 4; k++) begin
      occ[k] = rd_q[k][bit_idx];
    end
    reach[0] = 1'b1;
    for (int k = 1; k < 4; k++) begin
      reach[k] = reach[k-1] & occ[k-1];
    end
    place    = reach & ~occ;
    placed_d = |place;
    if (place[0]) begin
      level_d = LVL_PRIMARY;
      slot_d  = SlotW'(job_q.hash);
    end else if (place[1]) begin
      level_d = LVL_SECOND;
      slot_d  = Level1Base | SlotW'(job_q.hash[9:0]);
    end else if (place[2]) begin
      level_d = LVL_THIRD;
      slot_d  = Level2Base | SlotW'(job_q.hash[8:0]);
    end else begin
      level_d = LVL_FOURTH;
      slot_d  = Level3Base | SlotW'(job_q.hash[8:0]);
    end
  end

  // Counter updates for one insert
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      col_d[k] = (reach[k] && occ[k]) ? sat_inc(col_q[k]) : col_q[k];
    end
    for (int k = 0; k < 3; k++) begin
      prb_d[k] = reach[k+1] ? sat_inc(prb_q[k]) : prb_q[k];
    end
  end

  // Bank write port: zero rows while sweeping, set one bit after a probe
  always_comb begin
    bit_mask = RowW'(1) << bit_idx;
    for (int k = 0; k < 4; k++) begin
      we[k] = (state_q == ST_SWEEP) || ((state_q == ST_EVAL) && place[k]);
      wd[k] = (state_q == ST_SWEEP) ? '0 : (rd_q[k] | bit_mask);
    end
    if (state_q == ST_SWEEP) begin
      wa0 = sweep_row_q;
      wa1 = sweep_row_q[Row1W-1:0];
      wa2 = sweep_row_q[Row2W-1:0];
    end else begin
      wa0 = job_q.hash[BitIdxW +: Row0W];
      wa1 = job_q.hash[BitIdxW +: Row1W];
      wa2 = job_q.hash[BitIdxW +: Row2W];
    end
  end

  // Bank memories, read at the queue head hash
  always_ff @(posedge clk_i) begin
    if (we[0]) begin
      bank0_mem[wa0] <= wd[0];
    end
    rd_q[0] <= bank0_mem[req_i.job.hash[BitIdxW +: Row0W]];
  end

  always_ff @(posedge clk_i) begin
    if (we[1]) begin
      bank1_mem[wa1] <= wd[1];
    end
    rd_q[1] <= bank1_mem[req_i.job.hash[BitIdxW +: Row1W]];
  end

  always_ff @(posedge clk_i) begin
    if (we[2]) begin
      bank2_mem[wa2] <= wd[2];
    end
    rd_q[2] <= bank2_mem[req_i.job.hash[BitIdxW +: Row2W]];
  end

  always_ff @(posedge clk_i) begin
    if (we[3]) begin
      bank3_mem[wa2] <= wd[3];
    end
    rd_q[3] <= bank3_mem[req_i.job.hash[BitIdxW +: Row2W]];
  end

  // Sequencer, counters and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      sweep_row_q <= '0;
      reply_q     <= 1'b0;
      job_q       <= '0;
      out_valid_q <= 1'b0;
      placed_q    <= 1'b0;
      level_q     <= LVL_PRIMARY;
      slot_q      <= '0;
      for (int k = 0; k < 4; k++) begin
        col_q[k] <= '0;
      end
      for (int k = 0; k < 3; k++) begin
        prb_q[k] <= '0;
      end
    end else begin
      // Drop the result once it is transferred
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_SWEEP: begin
          sweep_row_q <= sweep_row_q + 1'b1;
          if (sweep_row_q == Row0W'(Bank0Rows - 1)) begin
            state_q <= ST_IDLE;
            if (reply_q) begin
              out_valid_q <= 1'b1;
              placed_q    <= 1'b0;
              level_q     <= LVL_PRIMARY;
              slot_q      <= '0;
            end
          end
        end
        ST_IDLE: begin
          if (clr_start) begin
            state_q     <= ST_SWEEP;
            sweep_row_q <= '0;
            reply_q     <= 1'b1;
            for (int k = 0; k < 4; k++) begin
              col_q[k] <= '0;
            end
            for (int k = 0; k < 3; k++) begin
              prb_q[k] <= '0;
            end
          end else if (pop_o) begin
            job_q   <= req_i.job;
            state_q <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          state_q     <= ST_IDLE;
          out_valid_q <= 1'b1;
          placed_q    <= placed_d;
          level_q     <= level_d;
          slot_q      <= slot_d;
          col_q       <= col_d;
          prb_q       <= prb_d;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Counter snapshot: low 32 bits, zero-extended for narrow counters
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      col_x[k] = ExtW'(col_q[k]);
    end
    for (int k = 0; k < 3; k++) begin
      prb_x[k] = ExtW'(prb_q[k]);
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.placed            = placed_q;
  assign out_o.level             = level_q;
  assign out_o.slot              = slot_q;
  assign out_o.collisions_level1 = col_x[0][OutCntW-1:0];
  assign out_o.collisions_level2 = col_x[1][OutCntW-1:0];
  assign out_o.collisions_level3 = col_x[2][OutCntW-1:0];
  assign out_o.collisions_level4 = col_x[3][OutCntW-1:0];
  assign out_o.probes_level2     = prb_x[0][OutCntW-1:0];
  assign out_o.probes_level3     = prb_x[1][OutCntW-1:0];
  assign out_o.probes_level4     = prb_x[2][OutCntW-1:0];

  // An insert marks at most one slot
  `MTHI_ASSERT(a_single_bank_write, (state_q == ST_EVAL) |-> $onehot0(we))
  // An insert evaluation is followed by idle in the next cycle
  `MTHI_ASSERT_NEXT(a_eval_one_cycle, state_q == ST_EVAL, state_q == ST_IDLE)
  // A result appears only after an insert or a requested sweep
  `MTHI_ASSERT(a_result_source,
    $rose(out_valid_q) |-> ($past(state_q) == ST_EVAL || $past(state_q) == ST_SWEEP))
  // Counters fall only through a clear
  `MTHI_ASSERT(a_counter_monotonic, (col_q[0] < $past(col_q[0])) |-> $past(clr_start))

endmodule

### rtl/mac_table_hash_insert.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mac_table_hash_insert
// MAC address learning table: XOR-fold hash into a 4096-slot occupancy
// table with three overflow levels and saturating per-level counters.
// ---------------------------------------------------------------------------
// Usage:
//   in_i  carries op (insert or clear) and a 48-bit MAC address; out_o
//   returns one result per request: placed, level, slot and the seven
//   counters as they stand after the request.
//   An insert passes the job queue, the bank read and the evaluate state
//   into the result register; the table takes one insert at a time, set
//   by the read-then-update access of the occupancy banks (all four banks
//   are read in one cycle, at most one is written in the next).
//   A clear zeroes the counters at once and sweeps the banks one 32-slot
//   row per cycle over the 64 rows of bank 0, then its result appears.
//   After reset the same sweep runs with no result; in_i.ready
//   stays low during any sweep.
//   A two-entry job queue separates the request side from the table; when
//   out_o is stalled the result is held, the queue fills and in_i.ready
//   falls once two jobs wait.
// ---------------------------------------------------------------------------
module mac_table_hash_insert import mthi_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mthi_in_if.sink    in_i,
  mthi_out_if.source out_o
);

  fe_req_t  req;
  be_stat_t stat;
  logic     pop;

  // Request side: hash and queue
  mthi_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .stat_i (stat),
    .pop_i  (pop),
    .req_o  (req)
  );

  // Table side: banks, counters, result register
  mthi_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .pop_o  (pop),
    .stat_o (stat),
    .out_o  (out_o)
  );

endmodule
